// File: src/fti_pkg.sv
package fti_pkg;

    localparam int FRAMES      = 256;
    localparam int TABLE_COUNT = 7;

    localparam int RAM_DEPTH = TABLE_COUNT * FRAMES;
    localparam int ADDR_W    = $clog2(RAM_DEPTH);
    localparam int IDX_W     = $clog2(FRAMES);

    typedef enum logic [1:0] {
        OP_READ   = 2'd0,
        OP_WRITE  = 2'd1,
        OP_INTERP = 2'd2,
        OP_NONE   = 2'd3
    } op_t;

    typedef struct packed {
        logic load;
        logic rd_en;
        logic wr_field;
        logic div_start;
        logic div_step;
        logic interp_init;
        logic interp_step;
        logic res_load;
        logic res_ram;
    } ctrl_cmd_t;

    typedef struct packed {
        op_t  op;
        logic sel_ok;
        logic span_short;
        logic loop_last;
    } dp_status_t;

    // frame index (0..255) folded into 0..FRAMES-1; FRAMES >= 16 keeps the
    // quotient within four bits, so four conditional subtracts suffice
    function automatic logic [IDX_W-1:0] frame_wrap(input logic [7:0] fr);
        logic [11:0] v;
        v = {4'd0, fr};
        for (int i = 3; i >= 0; i--) begin
            if (v >= 12'(FRAMES << i)) begin
                v = v - 12'(FRAMES << i);
            end
        end
        return v[IDX_W-1:0];
    endfunction

    function automatic logic [ADDR_W-1:0] table_addr(input logic [2:0] sel,
                                                     input logic [7:0] fr);
        logic [ADDR_W-1:0] base;
        base = ADDR_W'(sel) * ADDR_W'(FRAMES);
        return base + ADDR_W'(frame_wrap(fr));
    endfunction

endpackage

// File: src/frame_table_interpolator.sv
// Frame table interpolator: seven byte tables of speech frame parameters.
// Input stream (s_*): one transfer per command. s_tuser holds op and
// table_sel, s_tdata holds frame, write_value, span and delta.
// Output stream (m_*): exactly one transfer per command, carrying the
// entry read by a read command with a valid table_sel, else zero.
// Sequence: read, write and no-op commands pass from acceptance through
// the dispatch and finish states to the result. An interpolation of
// span >= 2 runs a restoring divide of |delta| by span, then one table
// write per frame through the single write port of the memory.
// One command is in work at a time; the next is accepted once the result
// sits in the output register, even while the receiver has not taken it.
// A stalled receiver (m_tready low) holds the result; a second result
// then waits inside the block, with s_tready low, until the first leaves.
// Reset (aresetn low, synchronous) returns the controller to idle and
// drops m_tvalid. Table contents are not cleared and are undefined until
// written.
module frame_table_interpolator (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,  // frame, write_value, span, delta
    input  logic [4:0]  s_tuser,  // op, table_sel
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata   // read_value
);

    import fti_pkg::*;

    ctrl_cmd_t  cmd;
    dp_status_t status;

    fti_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .status   (status),
        .cmd      (cmd)
    );

    fti_datapath u_datapath (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cmd        (cmd),
        .status     (status),
        .in_user    (s_tuser),
        .in_data    (s_tdata),
        .read_value (m_tdata)
    );

endmodule

// File: src/fti_ram.sv
module fti_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: src/fti_datapath.sv
module fti_datapath (
    input  logic                aclk,
    input  logic                aresetn,
    input  fti_pkg::ctrl_cmd_t  cmd,
    output fti_pkg::dp_status_t status,
    input  logic [4:0]          in_user,
    input  logic [31:0]         in_data,
    output logic [7:0]          read_value
);

    import fti_pkg::*;

    logic [1:0] op_reg;
    logic [2:0] sel_reg;
    logic [7:0] frame_reg;
    logic [7:0] wv_reg;
    logic [7:0] span_reg;
    logic [7:0] delta_reg;

    logic [7:0] div_r_reg;
    logic [7:0] div_q_reg;
    logic [7:0] val_reg;
    logic [7:0] err_reg;
    logic [7:0] fr_reg;
    logic [7:0] cnt_reg;
    logic [7:0] res_reg;

    logic [7:0] mag;
    logic [8:0] r_shift;
    logic       r_ge;
    logic [7:0] step;
    logic [8:0] err_sum;
    logic       hit;
    logic [7:0] err_next;
    logic [7:0] val_cur;
    logic [7:0] fr_next;

    logic [ADDR_W-1:0] field_addr;
    logic [ADDR_W-1:0] ram_waddr;
    logic [7:0]        ram_wdata;
    logic [7:0]        ram_rdata;

    assign mag = delta_reg[7] ? 8'(-delta_reg) : delta_reg;

    // restoring divide, one quotient bit per cycle
    assign r_shift = {div_r_reg, div_q_reg[7]};
    assign r_ge    = r_shift >= {1'b0, span_reg};

    assign step = delta_reg[7] ? 8'(-div_q_reg) : div_q_reg;

    // Bresenham correction for the current frame
    assign err_sum  = {1'b0, err_reg} + {1'b0, div_r_reg};
    assign hit      = err_sum >= {1'b0, span_reg};
    assign err_next = hit ? 8'(err_sum - {1'b0, span_reg}) : err_sum[7:0];

    always_comb begin
        val_cur = val_reg;
        if (hit) begin
            if (delta_reg[7]) begin
                val_cur = val_reg - 8'd1;
            end else if (val_reg != 8'd0) begin
                val_cur = val_reg + 8'd1;
            end
        end
    end

    assign fr_next = fr_reg + 8'd1;

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            op_reg    <= in_user[1:0];
            sel_reg   <= in_user[4:2];
            frame_reg <= in_data[7:0];
            wv_reg    <= in_data[15:8];
            span_reg  <= in_data[23:16];
            delta_reg <= in_data[31:24];
        end
        if (cmd.div_start) begin
            div_r_reg <= 8'd0;
            div_q_reg <= mag;
        end else if (cmd.div_step) begin
            div_r_reg <= r_ge ? 8'(r_shift - {1'b0, span_reg}) : r_shift[7:0];
            div_q_reg <= {div_q_reg[6:0], r_ge};
        end
        if (cmd.interp_init) begin
            val_reg <= ram_rdata + step;
            err_reg <= 8'd0;
            fr_reg  <= frame_reg;
            cnt_reg <= span_reg - 8'd1;
        end else if (cmd.interp_step) begin
            val_reg <= val_cur + step;
            err_reg <= err_next;
            fr_reg  <= fr_next;
            cnt_reg <= cnt_reg - 8'd1;
        end
        if (cmd.res_load) begin
            res_reg <= cmd.res_ram ? ram_rdata : 8'd0;
        end
    end

    assign field_addr = table_addr(sel_reg, frame_reg);
    assign ram_waddr  = cmd.wr_field ? field_addr : table_addr(sel_reg, fr_next);
    assign ram_wdata  = cmd.wr_field ? wv_reg : val_cur;

    fti_ram #(
        .WIDTH (8),
        .DEPTH (RAM_DEPTH)
    ) u_ram (
        .clk   (aclk),
        .we    (cmd.wr_field | cmd.interp_step),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (cmd.rd_en),
        .raddr (field_addr),
        .rdata (ram_rdata)
    );

    assign status.op         = op_t'(op_reg);
    assign status.sel_ok     = {1'b0, sel_reg} < 4'(TABLE_COUNT);
    assign status.span_short = span_reg < 8'd2;
    assign status.loop_last  = cnt_reg == 8'd1;

    assign read_value = res_reg;

    a_loop_count_live: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.interp_step |-> cnt_reg != 8'd0)
        else $error("interpolation step with exhausted frame count");

    a_err_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.interp_step |-> err_reg < span_reg)
        else $error("error term reached span");

    a_rem_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.interp_init |-> div_r_reg < span_reg && div_q_reg <= mag)
        else $error("divider result out of range");

endmodule

// File: src/fti_ctrl.sv
module fti_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    output logic                m_tvalid,
    input  logic                m_tready,
    input  fti_pkg::dp_status_t status,
    output fti_pkg::ctrl_cmd_t  cmd
);

    import fti_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DISPATCH,
        ST_DIV,
        ST_INIT,
        ST_INTERP,
        ST_FINISH
    } state_t;

    state_t     state_reg;
    logic [2:0] div_cnt_reg;
    logic       res_ram_reg;
    logic       m_valid_reg;
    logic       run_interp;
    logic       slot_free;

    assign run_interp = status.op == OP_INTERP && status.sel_ok && !status.span_short;
    assign slot_free  = !m_valid_reg || m_tready;

    always_comb begin
        cmd = '0;
        cmd.res_ram = res_ram_reg;
        unique case (state_reg)
            ST_IDLE: begin
                cmd.load = s_tvalid;
            end
            ST_DISPATCH: begin
                cmd.rd_en     = 1'b1;
                cmd.wr_field  = status.op == OP_WRITE && status.sel_ok;
                cmd.div_start = run_interp;
            end
            ST_DIV: begin
                cmd.div_step = 1'b1;
            end
            ST_INIT: begin
                cmd.interp_init = 1'b1;
            end
            ST_INTERP: begin
                cmd.interp_step = 1'b1;
            end
            ST_FINISH: begin
                cmd.res_load = slot_free;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            div_cnt_reg <= 3'd0;
            res_ram_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cmd.res_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (s_tvalid) begin
                        state_reg <= ST_DISPATCH;
                    end
                end
                ST_DISPATCH: begin
                    res_ram_reg <= status.op == OP_READ && status.sel_ok;
                    div_cnt_reg <= 3'd0;
                    state_reg   <= run_interp ? ST_DIV : ST_FINISH;
                end
                ST_DIV: begin
                    div_cnt_reg <= div_cnt_reg + 3'd1;
                    if (div_cnt_reg == 3'd7) begin
                        state_reg <= ST_INIT;
                    end
                end
                ST_INIT: begin
                    state_reg <= ST_INTERP;
                end
                ST_INTERP: begin
                    if (status.loop_last) begin
                        state_reg <= ST_FINISH;
                    end
                end
                ST_FINISH: begin
                    if (slot_free) begin
                        state_reg <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign s_tready = state_reg == ST_IDLE;
    assign m_tvalid = m_valid_reg;

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.res_load |-> !m_valid_reg || m_tready)
        else $error("result loaded over an untaken result");

    a_read_needs_ram: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.res_load && cmd.res_ram |-> $past(state_reg) == ST_DISPATCH
                                        || $past(state_reg) == ST_FINISH)
        else $error("read result not fresh from the memory");

    a_div_length: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.interp_init |-> $past(cmd.div_step) && $past(div_cnt_reg) == 3'd7)
        else $error("interpolation started before divide finished");

endmodule
